// ===== design/hset_pkg.sv =====
// Package for the transaction ID hash set: shared codes, defaults and the
// command and status structs that join the controller and the datapath.
// No dependencies.
package hset_pkg;

   localparam int unsigned BUCKET_COUNT_DEF = 521;
   localparam int unsigned CAPACITY_DEF     = 512;
   localparam int unsigned KEY_BITS_DEF     = 64;
   localparam int unsigned KEY_PORT_W       = 64;
   localparam int unsigned KIND_W           = 3;
   localparam int unsigned STATUS_W         = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT     = 3'd0,
      KIND_DELETE     = 3'd1,
      KIND_FIND       = 3'd2,
      KIND_SCAN_START = 3'd3,
      KIND_SCAN_NEXT  = 3'd4,
      KIND_CLEAR      = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_SCAN_BAD  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      DP_NONE,
      DP_LOAD,
      DP_HASH,
      DP_SWEEP,
      DP_INS_READ,
      DP_INS_LINK,
      DP_INS_FIN,
      DP_WALK_BH,
      DP_WALK_HEAD,
      DP_WALK_READ,
      DP_WALK_NEXT,
      DP_MISS,
      DP_FIND_HIT,
      DP_DEL_READ,
      DP_DEL_UNLINK,
      DP_SCAN_RD,
      DP_SCAN_SEL,
      DP_SCAN_KEY,
      DP_RESPOND
   } dp_op_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_HASH,
      S_INS_RD,
      S_INS_LINK,
      S_INS_FIN,
      S_WALK_BH,
      S_WALK_HEAD,
      S_WALK_RD,
      S_WALK_CHK,
      S_DEL_UNLINK,
      S_SCAN_RD,
      S_SCAN_SEL,
      S_SCAN_KEY,
      S_CLEAR,
      S_RESPOND
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     hash_last;
      logic     sweep_last;
      logic     full;
      logic     scan_valid;
      logic     cur_is_sent;
      logic     key_match;
      logic     cand_is_sent;
      logic     rsp_free;
   } dp_stat_type;

endpackage

// ===== design/hset_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hset_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hset_ctrl.sv =====
// Controller state machine of the hash set: sequences datapath commands.
// Depends on hset_pkg.
module hset_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [hset_pkg::KIND_W-1:0]      req_kind,
   output logic                             req_ready,
   output hset_pkg::dp_cmd_type             cmd,
   input  hset_pkg::dp_stat_type            status
);

   hset_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hset_pkg::S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = hset_pkg::DP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         hset_pkg::S_INIT: begin
            cmd.op = hset_pkg::DP_SWEEP;
            if (status.sweep_last) begin
               state_in = hset_pkg::S_IDLE;
            end
         end
         hset_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = hset_pkg::DP_LOAD;
               case (hset_pkg::kind_type'(req_kind))
                  hset_pkg::KIND_INSERT: begin
                     state_in = status.full ? hset_pkg::S_RESPOND : hset_pkg::S_HASH;
                  end
                  hset_pkg::KIND_DELETE, hset_pkg::KIND_FIND: begin
                     state_in = hset_pkg::S_HASH;
                  end
                  hset_pkg::KIND_SCAN_NEXT: begin
                     state_in = status.scan_valid ? hset_pkg::S_SCAN_RD
                                                  : hset_pkg::S_RESPOND;
                  end
                  hset_pkg::KIND_CLEAR: begin
                     state_in = hset_pkg::S_CLEAR;
                  end
                  default: begin
                     state_in = hset_pkg::S_RESPOND;
                  end
               endcase
            end
         end
         hset_pkg::S_HASH: begin
            cmd.op = hset_pkg::DP_HASH;
            if (status.hash_last) begin
               state_in = (status.kind == hset_pkg::KIND_INSERT) ? hset_pkg::S_INS_RD
                                                                  : hset_pkg::S_WALK_BH;
            end
         end
         hset_pkg::S_INS_RD: begin
            cmd.op   = hset_pkg::DP_INS_READ;
            state_in = hset_pkg::S_INS_LINK;
         end
         hset_pkg::S_INS_LINK: begin
            cmd.op   = hset_pkg::DP_INS_LINK;
            state_in = hset_pkg::S_INS_FIN;
         end
         hset_pkg::S_INS_FIN: begin
            cmd.op   = hset_pkg::DP_INS_FIN;
            state_in = hset_pkg::S_RESPOND;
         end
         hset_pkg::S_WALK_BH: begin
            cmd.op   = hset_pkg::DP_WALK_BH;
            state_in = hset_pkg::S_WALK_HEAD;
         end
         hset_pkg::S_WALK_HEAD: begin
            cmd.op   = hset_pkg::DP_WALK_HEAD;
            state_in = hset_pkg::S_WALK_RD;
         end
         hset_pkg::S_WALK_RD: begin
            if (status.cur_is_sent) begin
               cmd.op   = hset_pkg::DP_MISS;
               state_in = hset_pkg::S_RESPOND;
            end else begin
               cmd.op   = hset_pkg::DP_WALK_READ;
               state_in = hset_pkg::S_WALK_CHK;
            end
         end
         hset_pkg::S_WALK_CHK: begin
            if (!status.key_match) begin
               cmd.op   = hset_pkg::DP_WALK_NEXT;
               state_in = hset_pkg::S_WALK_RD;
            end else if (status.kind == hset_pkg::KIND_FIND) begin
               cmd.op   = hset_pkg::DP_FIND_HIT;
               state_in = hset_pkg::S_RESPOND;
            end else begin
               cmd.op   = hset_pkg::DP_DEL_READ;
               state_in = hset_pkg::S_DEL_UNLINK;
            end
         end
         hset_pkg::S_DEL_UNLINK: begin
            cmd.op   = hset_pkg::DP_DEL_UNLINK;
            state_in = hset_pkg::S_RESPOND;
         end
         hset_pkg::S_SCAN_RD: begin
            cmd.op   = hset_pkg::DP_SCAN_RD;
            state_in = hset_pkg::S_SCAN_SEL;
         end
         hset_pkg::S_SCAN_SEL: begin
            cmd.op   = hset_pkg::DP_SCAN_SEL;
            state_in = status.cand_is_sent ? hset_pkg::S_RESPOND : hset_pkg::S_SCAN_KEY;
         end
         hset_pkg::S_SCAN_KEY: begin
            cmd.op   = hset_pkg::DP_SCAN_KEY;
            state_in = hset_pkg::S_RESPOND;
         end
         hset_pkg::S_CLEAR: begin
            cmd.op = hset_pkg::DP_SWEEP;
            if (status.sweep_last) begin
               state_in = hset_pkg::S_RESPOND;
            end
         end
         hset_pkg::S_RESPOND: begin
            if (status.rsp_free) begin
               cmd.op   = hset_pkg::DP_RESPOND;
               state_in = hset_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = hset_pkg::S_INIT;
         end
      endcase
   end

endmodule

// ===== design/hset_dp.sv =====
// Datapath of the hash set: bucket hash unit, entry memories, list pointers,
// scan cursor and the result register. Depends on hset_pkg and hset_ram.
module hset_dp #(
   parameter int unsigned BUCKET_COUNT = hset_pkg::BUCKET_COUNT_DEF,
   parameter int unsigned CAPACITY     = hset_pkg::CAPACITY_DEF,
   parameter int unsigned KEY_BITS     = hset_pkg::KEY_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [hset_pkg::KIND_W-1:0]          req_kind,
   input  logic [hset_pkg::KEY_PORT_W-1:0]      req_key,
   input  hset_pkg::dp_cmd_type                 cmd,
   output hset_pkg::dp_stat_type                status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [hset_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_found,
   output logic [hset_pkg::KEY_PORT_W-1:0]      rsp_key_out,
   output logic [$clog2(CAPACITY)-1:0]          rsp_slot,
   output logic                                 rsp_scan_done,
   output logic [$clog2(CAPACITY+1)-1:0]        rsp_entry_count
);

   localparam int unsigned SLOT_W  = $clog2(CAPACITY);
   localparam int unsigned PTR_W   = $clog2(CAPACITY + 1);
   localparam int unsigned BKT_W   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int unsigned HSTEPS  = (KEY_BITS + 3) / 4;
   localparam int unsigned KEY_PAD = HSTEPS * 4;
   localparam int unsigned HS_W    = $clog2(HSTEPS);
   localparam int unsigned SWEEP_N = (BUCKET_COUNT > CAPACITY) ? BUCKET_COUNT : CAPACITY;
   localparam int unsigned SW_W    = $clog2(SWEEP_N);
   localparam logic [PTR_W-1:0] SENT   = PTR_W'(CAPACITY);
   localparam logic [BKT_W:0]   NB_EXT = (BKT_W + 1)'(BUCKET_COUNT);

   // Control state.
   logic [PTR_W-1:0] live_ff, live_in;
   logic [PTR_W-1:0] list_head_ff, list_head_in;
   logic [PTR_W-1:0] cursor_ff, cursor_in;
   logic             scan_valid_ff, scan_valid_in;
   logic [SW_W-1:0]  sweep_ff, sweep_in;
   logic [HS_W-1:0]  hstep_ff, hstep_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload state.
   hset_pkg::kind_type     kind_ff, kind_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [KEY_PAD-1:0]     hkey_ff, hkey_in;
   logic [BKT_W-1:0]       bucket_ff, bucket_in;
   logic [PTR_W-1:0]       cur_ff, cur_in;
   logic [PTR_W-1:0]       prev_ff, prev_in;
   logic [PTR_W-1:0]       cnext_ff, cnext_in;
   hset_pkg::status_type   res_status_ff, res_status_in;
   logic                   res_found_ff, res_found_in;
   logic [KEY_BITS-1:0]    res_key_ff, res_key_in;
   logic [SLOT_W-1:0]      res_slot_ff, res_slot_in;
   logic                   res_done_ff, res_done_in;
   hset_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [KEY_BITS-1:0]    rsp_key_ff, rsp_key_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic                   rsp_done_ff, rsp_done_in;
   logic [PTR_W-1:0]       rsp_count_ff, rsp_count_in;

   // Memory ports.
   logic                k_we, k_re;
   logic [SLOT_W-1:0]   k_wa, k_ra;
   logic [KEY_BITS-1:0] k_wd, k_rd;
   logic                c_we, c_re;
   logic [SLOT_W-1:0]   c_wa, c_ra;
   logic [PTR_W-1:0]    c_wd, c_rd;
   logic                n_we, n_re;
   logic [SLOT_W-1:0]   n_wa, n_ra;
   logic [PTR_W-1:0]    n_wd, n_rd;
   logic                p_we, p_re;
   logic [SLOT_W-1:0]   p_wa, p_ra;
   logic [PTR_W-1:0]    p_wd, p_rd;
   logic                b_we, b_re;
   logic [BKT_W-1:0]    b_wa, b_ra;
   logic [PTR_W-1:0]    b_wd, b_rd;
   logic                f_we, f_re;
   logic [SLOT_W-1:0]   f_wa, f_ra, f_rd;
   logic [SLOT_W-1:0]   f_wd;

   logic [BKT_W:0]      hash_t;
   logic [BKT_W-1:0]    hash_r;
   logic [PTR_W-1:0]    scan_cand;
   logic [PTR_W-1:0]    live_dec;
   logic                full;

   hset_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_keys (
      .clock, .wr_en(k_we), .wr_addr(k_wa), .wr_data(k_wd),
      .rd_en(k_re), .rd_addr(k_ra), .rd_data(k_rd));
   hset_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_chain (
      .clock, .wr_en(c_we), .wr_addr(c_wa), .wr_data(c_wd),
      .rd_en(c_re), .rd_addr(c_ra), .rd_data(c_rd));
   hset_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_lnext (
      .clock, .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd),
      .rd_en(n_re), .rd_addr(n_ra), .rd_data(n_rd));
   hset_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_lprev (
      .clock, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_en(p_re), .rd_addr(p_ra), .rd_data(p_rd));
   hset_ram #(.WIDTH(PTR_W), .DEPTH(BUCKET_COUNT)) u_heads (
      .clock, .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd),
      .rd_en(b_re), .rd_addr(b_ra), .rd_data(b_rd));
   hset_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free (
      .clock, .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_en(f_re), .rd_addr(f_ra), .rd_data(f_rd));

   // Four bits of the key per cycle, most significant first, one
   // conditional subtract each.
   always_comb begin
      hash_r = bucket_ff;
      hash_t = '0;
      for (int i = 0; i < 4; i++) begin
         hash_t = {hash_r, hkey_ff[KEY_PAD-1-i]};
         if (hash_t >= NB_EXT) begin
            hash_t = hash_t - NB_EXT;
         end
         hash_r = hash_t[BKT_W-1:0];
      end
   end

   assign scan_cand = (cursor_ff == SENT) ? list_head_ff : n_rd;
   assign live_dec  = live_ff - PTR_W'(1);
   assign full      = (live_ff >= SENT);

   assign status.kind         = kind_ff;
   assign status.hash_last    = (hstep_ff == HS_W'(HSTEPS - 1));
   assign status.sweep_last   = (sweep_ff == SW_W'(SWEEP_N - 1));
   assign status.full         = full;
   assign status.scan_valid   = scan_valid_ff;
   assign status.cur_is_sent  = (cur_ff == SENT);
   assign status.key_match    = (k_rd == key_ff);
   assign status.cand_is_sent = (scan_cand == SENT);
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      live_in       = live_ff;
      list_head_in  = list_head_ff;
      cursor_in     = cursor_ff;
      scan_valid_in = scan_valid_ff;
      sweep_in      = sweep_ff;
      hstep_in      = hstep_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      kind_in       = kind_ff;
      key_in        = key_ff;
      hkey_in       = hkey_ff;
      bucket_in     = bucket_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      cnext_in      = cnext_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_key_in    = res_key_ff;
      res_slot_in   = res_slot_ff;
      res_done_in   = res_done_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_count_in  = rsp_count_ff;
      k_we = 1'b0; k_wa = '0; k_wd = '0; k_re = 1'b0; k_ra = '0;
      c_we = 1'b0; c_wa = '0; c_wd = '0; c_re = 1'b0; c_ra = '0;
      n_we = 1'b0; n_wa = '0; n_wd = '0; n_re = 1'b0; n_ra = '0;
      p_we = 1'b0; p_wa = '0; p_wd = '0; p_re = 1'b0; p_ra = '0;
      b_we = 1'b0; b_wa = '0; b_wd = '0; b_re = 1'b0; b_ra = '0;
      f_we = 1'b0; f_wa = '0; f_wd = '0; f_re = 1'b0; f_ra = '0;
      case (cmd.op)
         hset_pkg::DP_LOAD: begin
            kind_in       = hset_pkg::kind_type'(req_kind);
            key_in        = req_key[KEY_BITS-1:0];
            hkey_in       = KEY_PAD'(req_key[KEY_BITS-1:0]);
            bucket_in     = '0;
            hstep_in      = '0;
            res_status_in = hset_pkg::ST_OK;
            res_found_in  = 1'b0;
            res_key_in    = '0;
            res_slot_in   = '0;
            res_done_in   = 1'b0;
            case (hset_pkg::kind_type'(req_kind))
               hset_pkg::KIND_INSERT: begin
                  scan_valid_in = 1'b0;
                  if (full) begin
                     res_status_in = hset_pkg::ST_FULL;
                  end
               end
               hset_pkg::KIND_DELETE: begin
                  scan_valid_in = 1'b0;
               end
               hset_pkg::KIND_SCAN_START: begin
                  cursor_in     = SENT;
                  scan_valid_in = 1'b1;
               end
               hset_pkg::KIND_SCAN_NEXT: begin
                  if (!scan_valid_ff) begin
                     res_status_in = hset_pkg::ST_SCAN_BAD;
                  end
               end
               hset_pkg::KIND_CLEAR: begin
                  live_in       = '0;
                  list_head_in  = SENT;
                  cursor_in     = SENT;
                  scan_valid_in = 1'b0;
                  sweep_in      = '0;
               end
               default: begin
               end
            endcase
         end
         hset_pkg::DP_HASH: begin
            hkey_in   = hkey_ff << 4;
            bucket_in = hash_r;
            hstep_in  = hstep_ff + HS_W'(1);
         end
         hset_pkg::DP_SWEEP: begin
            b_we     = ({1'b0, sweep_ff} < (SW_W + 1)'(BUCKET_COUNT));
            b_wa     = sweep_ff[BKT_W-1:0];
            b_wd     = SENT;
            f_we     = ({1'b0, sweep_ff} < (SW_W + 1)'(CAPACITY));
            f_wa     = sweep_ff[SLOT_W-1:0];
            f_wd     = sweep_ff[SLOT_W-1:0];
            sweep_in = sweep_ff + SW_W'(1);
         end
         hset_pkg::DP_INS_READ: begin
            b_re = 1'b1;
            b_ra = bucket_ff;
            f_re = 1'b1;
            f_ra = live_ff[SLOT_W-1:0];
         end
         hset_pkg::DP_INS_LINK: begin
            cur_in = PTR_W'(f_rd);
            k_we = 1'b1; k_wa = f_rd; k_wd = key_ff;
            c_we = 1'b1; c_wa = f_rd; c_wd = b_rd;
            n_we = 1'b1; n_wa = f_rd; n_wd = list_head_ff;
            p_we = (list_head_ff != SENT);
            p_wa = list_head_ff[SLOT_W-1:0];
            p_wd = PTR_W'(f_rd);
            b_we = 1'b1; b_wa = bucket_ff; b_wd = PTR_W'(f_rd);
         end
         hset_pkg::DP_INS_FIN: begin
            p_we = 1'b1; p_wa = cur_ff[SLOT_W-1:0]; p_wd = SENT;
            list_head_in = cur_ff;
            live_in      = live_ff + PTR_W'(1);
         end
         hset_pkg::DP_WALK_BH: begin
            b_re = 1'b1;
            b_ra = bucket_ff;
         end
         hset_pkg::DP_WALK_HEAD: begin
            cur_in  = b_rd;
            prev_in = SENT;
         end
         hset_pkg::DP_WALK_READ: begin
            k_re = 1'b1; k_ra = cur_ff[SLOT_W-1:0];
            c_re = 1'b1; c_ra = cur_ff[SLOT_W-1:0];
         end
         hset_pkg::DP_WALK_NEXT: begin
            prev_in = cur_ff;
            cur_in  = c_rd;
         end
         hset_pkg::DP_MISS: begin
            res_status_in = hset_pkg::ST_NOT_FOUND;
         end
         hset_pkg::DP_FIND_HIT: begin
            res_found_in = 1'b1;
            res_key_in   = key_ff;
            res_slot_in  = cur_ff[SLOT_W-1:0];
         end
         hset_pkg::DP_DEL_READ: begin
            p_re = 1'b1; p_ra = cur_ff[SLOT_W-1:0];
            n_re = 1'b1; n_ra = cur_ff[SLOT_W-1:0];
            cnext_in = c_rd;
         end
         hset_pkg::DP_DEL_UNLINK: begin
            if (p_rd != SENT) begin
               n_we = 1'b1; n_wa = p_rd[SLOT_W-1:0]; n_wd = n_rd;
            end else begin
               list_head_in = n_rd;
            end
            if (n_rd != SENT) begin
               p_we = 1'b1; p_wa = n_rd[SLOT_W-1:0]; p_wd = p_rd;
            end
            if (prev_ff != SENT) begin
               c_we = 1'b1; c_wa = prev_ff[SLOT_W-1:0]; c_wd = cnext_ff;
            end else begin
               b_we = 1'b1; b_wa = bucket_ff; b_wd = cnext_ff;
            end
            live_in = live_dec;
            f_we = 1'b1; f_wa = live_dec[SLOT_W-1:0]; f_wd = cur_ff[SLOT_W-1:0];
         end
         hset_pkg::DP_SCAN_RD: begin
            n_re = 1'b1;
            n_ra = cursor_ff[SLOT_W-1:0];
         end
         hset_pkg::DP_SCAN_SEL: begin
            if (scan_cand == SENT) begin
               cursor_in     = SENT;
               scan_valid_in = 1'b0;
               res_done_in   = 1'b1;
            end else begin
               cursor_in = scan_cand;
               k_re      = 1'b1;
               k_ra      = scan_cand[SLOT_W-1:0];
            end
         end
         hset_pkg::DP_SCAN_KEY: begin
            res_found_in = 1'b1;
            res_key_in   = k_rd;
            res_slot_in  = cursor_ff[SLOT_W-1:0];
         end
         hset_pkg::DP_RESPOND: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status_ff;
            rsp_found_in  = res_found_ff;
            rsp_key_in    = res_key_ff;
            rsp_slot_in   = res_slot_ff;
            rsp_done_in   = res_done_ff;
            rsp_count_in  = live_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff       <= '0;
         list_head_ff  <= SENT;
         cursor_ff     <= SENT;
         scan_valid_ff <= 1'b0;
         sweep_ff      <= '0;
         hstep_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         live_ff       <= live_in;
         list_head_ff  <= list_head_in;
         cursor_ff     <= cursor_in;
         scan_valid_ff <= scan_valid_in;
         sweep_ff      <= sweep_in;
         hstep_ff      <= hstep_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      hkey_ff       <= hkey_in;
      bucket_ff     <= bucket_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      cnext_ff      <= cnext_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_key_ff    <= res_key_in;
      res_slot_ff   <= res_slot_in;
      res_done_ff   <= res_done_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_key_out     = hset_pkg::KEY_PORT_W'(rsp_key_ff);
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_scan_done   = rsp_done_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== design/txn_id_hash_set.sv =====
// Top level of the transaction ID hash set: controller plus datapath.
// Depends on hset_pkg, hset_ctrl, hset_dp (and hset_ram through hset_dp).
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   req_kind, req_key
//   rsp_      out        rsp_valid/rsp_ready   rsp_status, rsp_found, rsp_key_out,
//                                              rsp_slot, rsp_scan_done,
//                                              rsp_entry_count
//
// One request is in work at a time. Insert (unless the set is full), delete
// and find first run the key through the bucket hash unit, which folds four
// key bits per cycle. Insert then reads the bucket head and a free slot,
// links the entry and finishes the list; find and delete walk the bucket's
// chain, and a delete that hits unlinks the entry. The chain walk is paced
// by the registered read of the key and chain memories. Start scan, unknown
// kinds and a scan next on a closed scan go straight to the response; a scan
// next step reads the list link, selects the next entry and reads its key,
// except at the end of the list. Clear sweeps the bucket heads and the
// free-slot stack, one entry per cycle, over the larger of BUCKET_COUNT and
// CAPACITY entries (521 by default). The same sweep runs after reset, and
// req_ready stays low until it is done. The result waits in an output
// register; a request is taken while a result is still held, and the block
// stalls at the end of its work only if that earlier result is not taken.
module txn_id_hash_set #(
   parameter int unsigned BUCKET_COUNT = hset_pkg::BUCKET_COUNT_DEF,
   parameter int unsigned CAPACITY     = hset_pkg::CAPACITY_DEF,
   parameter int unsigned KEY_BITS     = hset_pkg::KEY_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [hset_pkg::KIND_W-1:0]          req_kind,
   input  logic [hset_pkg::KEY_PORT_W-1:0]      req_key,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [hset_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_found,
   output logic [hset_pkg::KEY_PORT_W-1:0]      rsp_key_out,
   output logic [$clog2(CAPACITY)-1:0]          rsp_slot,
   output logic                                 rsp_scan_done,
   output logic [$clog2(CAPACITY+1)-1:0]        rsp_entry_count
);

   hset_pkg::dp_cmd_type  cmd;
   hset_pkg::dp_stat_type status;

   // The controller only decides what happens next; all storage lives in
   // the datapath.
   hset_ctrl u_ctrl (
      .clock,
      .reset,
      .req_valid,
      .req_kind,
      .req_ready,
      .cmd,
      .status
   );

   hset_dp #(
      .BUCKET_COUNT(BUCKET_COUNT),
      .CAPACITY(CAPACITY),
      .KEY_BITS(KEY_BITS)
   ) u_dp (
      .clock,
      .reset,
      .req_kind,
      .req_key,
      .cmd,
      .status,
      .rsp_ready,
      .rsp_valid,
      .rsp_status,
      .rsp_found,
      .rsp_key_out,
      .rsp_slot,
      .rsp_scan_done,
      .rsp_entry_count
   );

   // Work on one request at a time: an accepted request closes the door.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another was in work");

   // The live count never exceeds the pool size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= ($clog2(CAPACITY+1))'(CAPACITY)))
      else $error("entry count beyond capacity");

   // A returned entry always comes with ok status and never with scan end.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         (rsp_status == hset_pkg::ST_OK) && !rsp_scan_done)
      else $error("entry returned with error status or scan end");

   // A result is only loaded when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == hset_pkg::DP_RESPOND) |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over an untaken result");

endmodule
